### design/ccls_pkg.sv
// Shared types, widths and constants for the color sensor classifier.
`default_nettype none
package ccls_pkg;

  localparam int PERIOD_W = 24;
  localparam int LVL_W    = 10;
  localparam int PROD_W   = PERIOD_W + LVL_W;
  localparam int DIV_CNT_W = $clog2(LVL_W);
  localparam int NCHAN    = 4;
  localparam int CH_W     = $clog2(NCHAN);
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic [LVL_W-1:0] FULL_SCALE = LVL_W'(1000);

  localparam logic [CH_W-1:0] CH_RED   = CH_W'(0);
  localparam logic [CH_W-1:0] CH_WHITE = CH_W'(1);
  localparam logic [CH_W-1:0] CH_BLUE  = CH_W'(2);
  localparam logic [CH_W-1:0] CH_GREEN = CH_W'(3);
  localparam logic [CH_W-1:0] CH_LAST  = CH_W'(NCHAN - 1);

  localparam logic [2:0] REG_DARK_LIMIT         = 3'd0;
  localparam logic [2:0] REG_BROWN_LIMIT        = 3'd1;
  localparam logic [2:0] REG_GLOW_LIMIT         = 3'd2;
  localparam logic [2:0] REG_PURPLE_RED_LIMIT   = 3'd3;
  localparam logic [2:0] REG_YELLOW_WHITE_LIMIT = 3'd4;
  localparam logic [2:0] REG_ORANGE_RED_LIMIT   = 3'd5;
  localparam logic [2:0] REG_RED_GREEN_LIMIT    = 3'd6;

  localparam logic [LVL_W-1:0] DARK_RESET         = LVL_W'(100);
  localparam logic [LVL_W-1:0] BROWN_RESET        = LVL_W'(350);
  localparam logic [LVL_W-1:0] GLOW_RESET         = LVL_W'(950);
  localparam logic [LVL_W-1:0] PURPLE_RED_RESET   = LVL_W'(550);
  localparam logic [LVL_W-1:0] YELLOW_WHITE_RESET = LVL_W'(450);
  localparam logic [LVL_W-1:0] ORANGE_RED_RESET   = LVL_W'(780);
  localparam logic [LVL_W-1:0] RED_GREEN_RESET    = LVL_W'(400);

  typedef logic [PERIOD_W-1:0] period_t;
  typedef logic [LVL_W-1:0]    level_t;

  localparam period_t LO_RESET [NCHAN] = '{
    PERIOD_W'(7716), PERIOD_W'(5692), PERIOD_W'(8436), PERIOD_W'(9816)
  };
  localparam period_t HI_RESET [NCHAN] = '{
    PERIOD_W'(578736), PERIOD_W'(215144), PERIOD_W'(744488), PERIOD_W'(744660)
  };

  typedef enum logic [3:0] {
    CLS_BLACK  = 4'd0,
    CLS_BROWN  = 4'd1,
    CLS_GLOW   = 4'd2,
    CLS_GREEN  = 4'd3,
    CLS_PURPLE = 4'd4,
    CLS_BLUE   = 4'd5,
    CLS_YELLOW = 4'd6,
    CLS_ORANGE = 4'd7,
    CLS_GREY   = 4'd8,
    CLS_RED    = 4'd9,
    CLS_PINK   = 4'd10
  } color_class_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BOUND,
    ST_PREP,
    ST_START,
    ST_DIV,
    ST_OUT
  } seq_state_t;

endpackage
`default_nettype wire

### design/ccls_div.sv
// Restoring divider, one quotient bit per cycle, for the level scaling.
`default_nettype none
module ccls_div
  import ccls_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [PROD_W-1:0]    dividend,
  input  wire logic [PERIOD_W-1:0]  divisor,
  output logic                      done,
  output logic [LVL_W-1:0]          quotient
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [PROD_W-1:0]    rem_r;
  logic [PROD_W-1:0]    dsh_r;
  logic [LVL_W-1:0]     q_r;
  logic                 ge;

  // The quotient is known to stay below 2**LVL_W, so the divisor starts
  // aligned to the top quotient bit.
  assign ge = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(LVL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dsh_r <= PROD_W'({divisor, {(LVL_W-1){1'b0}}});
      q_r   <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      dsh_r <= dsh_r >> 1;
      q_r   <= {q_r[LVL_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
`default_nettype wire

### design/color_sensor_classifier_core.sv
// Top level of the color sensor classifier: bounds, sequencer, classifier, register port.
// Each channel passes through bound, prepare and start, ten divider steps and done.
// One word is in work at a time; in_stall is high while a word is in work.
// Reset (synchronous, rst_n low) restores calibration bounds and limit registers.
// A finished result waits in the output register while the next word is taken.
`default_nettype none
module color_sensor_classifier_core
  import ccls_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [PERIOD_W-1:0] in_period_red,
  input  wire logic [PERIOD_W-1:0] in_period_white,
  input  wire logic [PERIOD_W-1:0] in_period_blue,
  input  wire logic [PERIOD_W-1:0] in_period_green,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [LVL_W-1:0]         out_level_red,
  output logic [LVL_W-1:0]         out_level_white,
  output logic [LVL_W-1:0]         out_level_blue,
  output logic [LVL_W-1:0]         out_level_green,
  output logic [3:0]               out_color_class,
  // configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  // Limit registers.
  level_t dark_r, brown_r, glow_r, purple_red_r, yellow_white_r, orange_red_r, red_green_r;
  logic   cfg_wr;
  logic [2:0] cfg_idx;

  // Sequencer and datapath state.
  seq_state_t state_r, state_nxt;
  logic [CH_W-1:0] ch_r;
  period_t per_r [NCHAN];
  period_t lo_r  [NCHAN];
  period_t hi_r  [NCHAN];
  level_t  lvl_r [NCHAN];
  period_t diff_r, span_r;
  period_t p_cur, lo_cur, hi_cur;

  // Divider hookup.
  logic               div_start;
  logic               div_done;
  logic [PROD_W-1:0]  dividend;
  level_t             quot;
  level_t             level_nxt;

  // Output register.
  logic         out_valid_r;
  level_t       out_lvl_r [NCHAN];
  color_class_t out_class_r;
  color_class_t class_nxt;
  logic         out_load;

  // ---------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; pready is
  // tied high so there are never wait states. Index seven is ignored.
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_r         <= DARK_RESET;
      brown_r        <= BROWN_RESET;
      glow_r         <= GLOW_RESET;
      purple_red_r   <= PURPLE_RED_RESET;
      yellow_white_r <= YELLOW_WHITE_RESET;
      orange_red_r   <= ORANGE_RED_RESET;
      red_green_r    <= RED_GREEN_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DARK_LIMIT:         dark_r         <= pwdata[LVL_W-1:0];
        REG_BROWN_LIMIT:        brown_r        <= pwdata[LVL_W-1:0];
        REG_GLOW_LIMIT:         glow_r         <= pwdata[LVL_W-1:0];
        REG_PURPLE_RED_LIMIT:   purple_red_r   <= pwdata[LVL_W-1:0];
        REG_YELLOW_WHITE_LIMIT: yellow_white_r <= pwdata[LVL_W-1:0];
        REG_ORANGE_RED_LIMIT:   orange_red_r   <= pwdata[LVL_W-1:0];
        REG_RED_GREEN_LIMIT:    red_green_r    <= pwdata[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_DARK_LIMIT:         prdata = DATA_W'(dark_r);
      REG_BROWN_LIMIT:        prdata = DATA_W'(brown_r);
      REG_GLOW_LIMIT:         prdata = DATA_W'(glow_r);
      REG_PURPLE_RED_LIMIT:   prdata = DATA_W'(purple_red_r);
      REG_YELLOW_WHITE_LIMIT: prdata = DATA_W'(yellow_white_r);
      REG_ORANGE_RED_LIMIT:   prdata = DATA_W'(orange_red_r);
      REG_RED_GREEN_LIMIT:    prdata = DATA_W'(red_green_r);
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer. For each channel in turn: widen the bounds, form the
  // offset and span, start the divider, then write the level when the
  // divider reports done. After the last channel the result word is
  // loaded into the output register once that register is free.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = ST_BOUND;
        end
      end
      ST_BOUND: state_nxt = ST_PREP;
      ST_PREP:  state_nxt = ST_START;
      ST_START: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = (ch_r == CH_LAST) ? ST_OUT : ST_BOUND;
        end
      end
      ST_OUT: begin
        // The previous result must have left before this one is loaded.
        if (!(out_valid_r && out_stall)) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r <= '0;
    end else if (state_r == ST_IDLE) begin
      ch_r <= '0;
    end else if (state_r == ST_DIV && div_done) begin
      ch_r <= ch_r + CH_W'(1);
    end
  end

  // Captured input word.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      per_r[CH_RED]   <= in_period_red;
      per_r[CH_WHITE] <= in_period_white;
      per_r[CH_BLUE]  <= in_period_blue;
      per_r[CH_GREEN] <= in_period_green;
    end
  end

  assign p_cur  = per_r[ch_r];
  assign lo_cur = lo_r[ch_r];
  assign hi_cur = hi_r[ch_r];

  // Calibration bounds only ever widen, so lower stays below upper.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NCHAN; k++) begin
        lo_r[k] <= LO_RESET[k];
        hi_r[k] <= HI_RESET[k];
      end
    end else if (state_r == ST_BOUND) begin
      if (p_cur < lo_cur) begin
        lo_r[ch_r] <= p_cur;
      end
      if (p_cur > hi_cur) begin
        hi_r[ch_r] <= p_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_PREP) begin
      diff_r <= p_cur - lo_cur;
      span_r <= hi_cur - lo_cur;
    end
  end

  // The offset times full scale is taken into the divider's remainder
  // register at start, so the multiply has a register right after it.
  assign dividend = PROD_W'(diff_r) * PROD_W'(FULL_SCALE);

  ccls_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (span_r),
    .done     (div_done),
    .quotient (quot)
  );

  // A channel whose bounds coincide reads as level zero.
  always_comb begin
    if (span_r == '0 || quot > FULL_SCALE) begin
      level_nxt = '0;
    end else begin
      level_nxt = FULL_SCALE - quot;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DIV && div_done) begin
      lvl_r[ch_r] <= level_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Decision tree over the four levels, checked in priority order.
  // ---------------------------------------------------------------------
  always_comb begin
    level_t r, w, b, g;
    r = lvl_r[CH_RED];
    w = lvl_r[CH_WHITE];
    b = lvl_r[CH_BLUE];
    g = lvl_r[CH_GREEN];
    priority if (r <= dark_r && w <= dark_r && b <= dark_r && g <= dark_r) begin
      class_nxt = CLS_BLACK;
    end else if (r <= brown_r && w <= brown_r && b <= brown_r && g <= brown_r) begin
      class_nxt = CLS_BROWN;
    end else if (r >= glow_r && w >= glow_r && b >= glow_r && g >= glow_r) begin
      class_nxt = CLS_GLOW;
    end else if (g > b && g > r) begin
      class_nxt = CLS_GREEN;
    end else if (b > g && b > r) begin
      class_nxt = (r > purple_red_r) ? CLS_PURPLE : CLS_BLUE;
    end else if (w < r && w < b && w < g) begin
      if (w < yellow_white_r) begin
        class_nxt = CLS_YELLOW;
      end else if (r > orange_red_r) begin
        class_nxt = CLS_ORANGE;
      end else begin
        class_nxt = CLS_GREY;
      end
    end else begin
      class_nxt = (g < red_green_r) ? CLS_RED : CLS_PINK;
    end
  end

  // ---------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int k = 0; k < NCHAN; k++) begin
        out_lvl_r[k] <= lvl_r[k];
      end
      out_class_r <= class_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_level_red   = out_lvl_r[CH_RED];
  assign out_level_white = out_lvl_r[CH_WHITE];
  assign out_level_blue  = out_lvl_r[CH_BLUE];
  assign out_level_green = out_lvl_r[CH_GREEN];
  assign out_color_class = out_class_r;

endmodule
`default_nettype wire
